@@ rtl/core/priority_run_queue_dispatcher_assert.svh @@
// assertion macros for the run queue dispatcher checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef PRIORITY_RUN_QUEUE_DISPATCHER_ASSERT_SVH
`define PRIORITY_RUN_QUEUE_DISPATCHER_ASSERT_SVH

// same-cycle implication, masked during reset
`define PRQD_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prqd check failed");

// next-cycle implication, masked during reset
`define PRQD_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prqd check failed");

`endif

@@ rtl/core/prqd_pkg.sv @@
// shared constants, result type and helper function for the run queue dispatcher
// no dependencies
package prqd_pkg;

  // field widths
  localparam int ID_W   = 6;
  localparam int PRIO_W = 6;

  // level layout: local levels 0..NUM_LEVELS-1, real-time levels RT_FIRST_LEVEL..NUM_LEVELS-1
  localparam int NUM_LEVELS     = 64;
  localparam int RT_FIRST_LEVEL = 32;
  localparam int RT_LEVELS      = 32;
  localparam int RT_IDX_W       = $clog2(RT_LEVELS);
  localparam int NUM_THREADS    = 64;

  // head/tail store: local levels first, real-time levels after
  localparam int QUEUE_DEPTH = NUM_LEVELS + RT_LEVELS;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);

  // ready-vector scan in groups of eight
  localparam int SCAN_W     = NUM_LEVELS + RT_LEVELS;
  localparam int GROUP_W    = 8;
  localparam int GRP_BIT_W  = $clog2(GROUP_W);
  localparam int NUM_GROUPS = SCAN_W / GROUP_W;
  localparam int GRP_IDX_W  = $clog2(NUM_GROUPS);
  localparam int SCAN_POS_W = GRP_IDX_W + GRP_BIT_W;

  // request codes
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_PICK    = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   picked_id;
    logic [PRIO_W-1:0] picked_prio;
    logic              picked_realtime;
    logic              go_idle;
    logic              preempt;
    logic              bad_prio;
  } result_t;

  // index of the highest set bit in one scan group
  function automatic logic [GRP_BIT_W-1:0] top_in_group(input logic [GROUP_W-1:0] v);
    logic [GRP_BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      if (v[i]) idx = GRP_BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/core/prqd_chan_if.sv @@
// request and response channel interfaces of the run queue dispatcher
// depends on prqd_pkg
interface prqd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [prqd_pkg::ID_W-1:0]   thread_id;
  logic [prqd_pkg::PRIO_W-1:0] prio;
  logic                        realtime_req;

  modport source (output valid, action, thread_id, prio, realtime_req, input ready);
  modport sink   (input valid, action, thread_id, prio, realtime_req, output ready);
endinterface

interface prqd_out_if;
  logic                        valid;
  logic                        ready;
  logic [prqd_pkg::ID_W-1:0]   picked_id;
  logic [prqd_pkg::PRIO_W-1:0] picked_prio;
  logic                        picked_realtime;
  logic                        go_idle;
  logic                        preempt;
  logic                        bad_prio;

  modport source (output valid, picked_id, picked_prio, picked_realtime, go_idle, preempt,
                  bad_prio, input ready);
  modport sink   (input valid, picked_id, picked_prio, picked_realtime, go_idle, preempt,
                  bad_prio, output ready);
endinterface

@@ rtl/core/prqd_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module prqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/priority_run_queue_dispatcher.sv @@
// run queue dispatcher top level: sequencer, level bitmaps, current-thread record
// depends on prqd_pkg, prqd_chan_if and prqd_ram
//
//   channel  dir  handshake     carries
//   in_req   in   valid/ready   action, thread_id, prio, realtime_req
//   out_rsp  out  valid/ready   picked_id, picked_prio, picked_realtime,
//                               go_idle, preempt, bad_prio
//
// an enqueue goes through ST_ENQ and ST_RESP, with ST_ENQ_LINK between when its level is
// already occupied (tail read, link write); a pick's ready-vector scanner checks one group
// of eight levels a cycle over 12 groups from the top, then the head/tail rams are read and,
// for a level with more than one thread, the link ram; one request is in flight at a time;
// the response register lets the next request be accepted while a response is still stalled on out_rsp
// rst_n clears the bitmaps and the current-thread record; the rams need no clearing
module priority_run_queue_dispatcher (
  input logic       clk,
  input logic       rst_n,
  prqd_in_if.sink   in_req,
  prqd_out_if.source out_rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_ENQ_LINK,
    ST_SCAN,
    ST_PICK_CMP,
    ST_PICK_ADV,
    ST_RESP
  } state_t;

  localparam int ID_W   = prqd_pkg::ID_W;
  localparam int PRIO_W = prqd_pkg::PRIO_W;
  localparam int LINK_AW = $clog2(prqd_pkg::NUM_THREADS);

  // registers
  state_t                              state_r, state_nxt;
  logic [ID_W-1:0]                     id_r, id_nxt;
  logic [PRIO_W-1:0]                   prio_r, prio_nxt;
  logic                                rt_r, rt_nxt;
  logic [prqd_pkg::QADDR_W-1:0]        qaddr_r, qaddr_nxt;
  logic [prqd_pkg::GRP_IDX_W-1:0]      grp_r, grp_nxt;
  logic [prqd_pkg::NUM_LEVELS-1:0]     lvl_map_r, lvl_map_nxt;
  logic [prqd_pkg::RT_LEVELS-1:0]      rt_map_r, rt_map_nxt;
  logic                                cur_idle_r, cur_idle_nxt;
  logic [PRIO_W-1:0]                   cur_prio_r, cur_prio_nxt;
  logic                                cur_rt_r, cur_rt_nxt;
  prqd_pkg::result_t                   res_r, res_nxt;
  prqd_pkg::result_t                   out_r, out_nxt;
  logic                                out_valid_r, out_valid_nxt;

  // ram ports
  logic                                head_we, tail_we, link_we;
  logic [ID_W-1:0]                     head_wdata;
  logic                                head_re, tail_re, link_re;
  logic [prqd_pkg::QADDR_W-1:0]        q_raddr;
  logic [ID_W-1:0]                     head_rdata, tail_rdata, link_rdata;

  // scan datapath
  logic [prqd_pkg::SCAN_W-1:0]         ready_vec;
  logic [prqd_pkg::GROUP_W-1:0]        grp_bits;
  logic [prqd_pkg::SCAN_POS_W-1:0]     scan_pos;
  logic [prqd_pkg::SCAN_POS_W-1:0]     scan_off;
  logic [prqd_pkg::RT_IDX_W-1:0]       scan_rt_idx;
  logic                                scan_rt;
  logic [PRIO_W-1:0]                   scan_level;
  logic [prqd_pkg::QADDR_W-1:0]        scan_qaddr;
  logic                                scan_hit;

  // enqueue decode of the incoming request
  logic [PRIO_W-1:0]                   in_prio_off;
  logic [prqd_pkg::RT_IDX_W-1:0]       in_rt_idx;
  logic [prqd_pkg::RT_IDX_W-1:0]       cur_rt_idx;
  logic [PRIO_W-1:0]                   prio_off_r;
  logic                                level_busy;
  logic                                enq_bad;
  logic                                enq_preempt;

  assign in_prio_off = in_req.prio - PRIO_W'(prqd_pkg::RT_FIRST_LEVEL);
  assign in_rt_idx   = in_prio_off[prqd_pkg::RT_IDX_W-1:0];
  assign prio_off_r  = prio_r - PRIO_W'(prqd_pkg::RT_FIRST_LEVEL);
  assign cur_rt_idx  = prio_off_r[prqd_pkg::RT_IDX_W-1:0];

  // level occupancy of the held request (prio always fits the local levels)
  assign level_busy = rt_r ? rt_map_r[cur_rt_idx] : lvl_map_r[prio_r];
  assign enq_bad    = rt_r && (prio_r < PRIO_W'(prqd_pkg::RT_FIRST_LEVEL));

  // preempt rule: idle always loses; rt needs higher prio only against rt
  always_comb begin
    if (cur_idle_r) begin
      enq_preempt = 1'b1;
    end else if (rt_r) begin
      enq_preempt = !cur_rt_r || (prio_r > cur_prio_r);
    end else begin
      enq_preempt = prio_r >= cur_prio_r;
    end
  end

  // ready vector: local low levels, then local/rt pairs with rt above on ties
  always_comb begin
    ready_vec = '0;
    for (int j = 0; j < prqd_pkg::RT_FIRST_LEVEL; j++) begin
      ready_vec[j] = lvl_map_r[j];
    end
    for (int j = 0; j < prqd_pkg::RT_LEVELS; j++) begin
      ready_vec[prqd_pkg::RT_FIRST_LEVEL + 2*j]     = lvl_map_r[prqd_pkg::RT_FIRST_LEVEL + j];
      ready_vec[prqd_pkg::RT_FIRST_LEVEL + 2*j + 1] = rt_map_r[j];
    end
  end

  // one scan group per cycle, highest set position inside it
  assign grp_bits = ready_vec[grp_r*prqd_pkg::GROUP_W +: prqd_pkg::GROUP_W];
  assign scan_hit = |grp_bits;
  assign scan_pos = {grp_r, prqd_pkg::top_in_group(grp_bits)};
  assign scan_off = scan_pos - prqd_pkg::SCAN_POS_W'(prqd_pkg::RT_FIRST_LEVEL);
  assign scan_rt_idx = scan_off[prqd_pkg::RT_IDX_W:1];

  // map scan position back to level, class and queue address
  always_comb begin
    if (scan_pos < prqd_pkg::SCAN_POS_W'(prqd_pkg::RT_FIRST_LEVEL)) begin
      scan_rt    = 1'b0;
      scan_level = scan_pos[PRIO_W-1:0];
      scan_qaddr = prqd_pkg::QADDR_W'(scan_pos);
    end else begin
      scan_rt    = scan_off[0];
      scan_level = PRIO_W'(prqd_pkg::RT_FIRST_LEVEL) + PRIO_W'(scan_rt_idx);
      scan_qaddr = scan_off[0]
                 ? prqd_pkg::QADDR_W'(prqd_pkg::NUM_LEVELS) + prqd_pkg::QADDR_W'(scan_rt_idx)
                 : prqd_pkg::QADDR_W'(scan_level);
    end
  end

  // ram read/write controls
  always_comb begin
    q_raddr    = (state_r == ST_SCAN) ? scan_qaddr : qaddr_r;
    head_re    = (state_r == ST_SCAN) && scan_hit;
    tail_re    = head_re || ((state_r == ST_ENQ) && !enq_bad && level_busy);
    link_re    = (state_r == ST_PICK_CMP) && (head_rdata != tail_rdata);
    link_we    = (state_r == ST_ENQ_LINK);
    tail_we    = link_we || ((state_r == ST_ENQ) && !enq_bad && !level_busy);
    head_we    = ((state_r == ST_ENQ) && !enq_bad && !level_busy) || (state_r == ST_PICK_ADV);
    head_wdata = (state_r == ST_PICK_ADV) ? link_rdata : id_r;
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    prio_nxt      = prio_r;
    rt_nxt        = rt_r;
    qaddr_nxt     = qaddr_r;
    grp_nxt       = grp_r;
    lvl_map_nxt   = lvl_map_r;
    rt_map_nxt    = rt_map_r;
    cur_idle_nxt  = cur_idle_r;
    cur_prio_nxt  = cur_prio_r;
    cur_rt_nxt    = cur_rt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;

    unique case (state_r)
      // latch the request
      ST_IDLE: begin
        if (in_req.valid) begin
          id_nxt    = in_req.thread_id;
          prio_nxt  = in_req.prio;
          rt_nxt    = in_req.realtime_req;
          qaddr_nxt = in_req.realtime_req
                    ? prqd_pkg::QADDR_W'(prqd_pkg::NUM_LEVELS) + prqd_pkg::QADDR_W'(in_rt_idx)
                    : prqd_pkg::QADDR_W'(in_req.prio);
          grp_nxt   = prqd_pkg::GRP_IDX_W'(prqd_pkg::NUM_GROUPS - 1);
          state_nxt = (in_req.action == prqd_pkg::ACT_PICK) ? ST_SCAN : ST_ENQ;
        end
      end

      // enqueue: drop bad rt prio, start empty level, or fetch old tail
      ST_ENQ: begin
        res_nxt = '0;
        if (enq_bad) begin
          res_nxt.bad_prio = 1'b1;
          state_nxt        = ST_RESP;
        end else begin
          res_nxt.preempt = enq_preempt;
          if (rt_r) rt_map_nxt[cur_rt_idx] = 1'b1;
          else      lvl_map_nxt[prio_r]    = 1'b1;
          state_nxt = level_busy ? ST_ENQ_LINK : ST_RESP;
        end
      end

      // old tail links to the new thread (writes done by ram controls)
      ST_ENQ_LINK: begin
        state_nxt = ST_RESP;
      end

      // walk groups from the top; nothing ready means idle
      ST_SCAN: begin
        if (scan_hit) begin
          prio_nxt  = scan_level;
          rt_nxt    = scan_rt;
          qaddr_nxt = scan_qaddr;
          state_nxt = ST_PICK_CMP;
        end else if (grp_r == '0) begin
          res_nxt         = '0;
          res_nxt.go_idle = 1'b1;
          cur_idle_nxt    = 1'b1;
          cur_prio_nxt    = '0;
          cur_rt_nxt      = 1'b0;
          state_nxt       = ST_RESP;
        end else begin
          grp_nxt = grp_r - prqd_pkg::GRP_IDX_W'(1);
        end
      end

      // head is the pick; last entry empties the level, else advance head
      ST_PICK_CMP: begin
        res_nxt                 = '0;
        res_nxt.picked_id       = head_rdata;
        res_nxt.picked_prio     = prio_r;
        res_nxt.picked_realtime = rt_r;
        cur_idle_nxt            = 1'b0;
        cur_prio_nxt            = prio_r;
        cur_rt_nxt              = rt_r;
        if (head_rdata == tail_rdata) begin
          if (rt_r) rt_map_nxt[cur_rt_idx] = 1'b0;
          else      lvl_map_nxt[prio_r]    = 1'b0;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_PICK_ADV;
        end
      end

      // new head written from the link read
      ST_PICK_ADV: begin
        state_nxt = ST_RESP;
      end

      // hand result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_map_r   <= '0;
      rt_map_r    <= '0;
      cur_idle_r  <= 1'b1;
      cur_prio_r  <= '0;
      cur_rt_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_map_r   <= lvl_map_nxt;
      rt_map_r    <= rt_map_nxt;
      cur_idle_r  <= cur_idle_nxt;
      cur_prio_r  <= cur_prio_nxt;
      cur_rt_r    <= cur_rt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r    <= id_nxt;
    prio_r  <= prio_nxt;
    rt_r    <= rt_nxt;
    qaddr_r <= qaddr_nxt;
    grp_r   <= grp_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // head pointers of every local and rt level
  prqd_ram #(.WIDTH(ID_W), .DEPTH(prqd_pkg::QUEUE_DEPTH)) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (qaddr_r),
    .wr_data (head_wdata),
    .rd_en   (head_re),
    .rd_addr (q_raddr),
    .rd_data (head_rdata)
  );

  // tail pointers of every local and rt level
  prqd_ram #(.WIDTH(ID_W), .DEPTH(prqd_pkg::QUEUE_DEPTH)) u_tail_ram (
    .clk     (clk),
    .wr_en   (tail_we),
    .wr_addr (qaddr_r),
    .wr_data (id_r),
    .rd_en   (tail_re),
    .rd_addr (q_raddr),
    .rd_data (tail_rdata)
  );

  // per-thread next links
  prqd_ram #(.WIDTH(ID_W), .DEPTH(prqd_pkg::NUM_THREADS)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (tail_rdata[LINK_AW-1:0]),
    .wr_data (id_r),
    .rd_en   (link_re),
    .rd_addr (head_rdata[LINK_AW-1:0]),
    .rd_data (link_rdata)
  );

  // ports
  assign in_req.ready            = (state_r == ST_IDLE);
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.picked_id       = out_r.picked_id;
  assign out_rsp.picked_prio     = out_r.picked_prio;
  assign out_rsp.picked_realtime = out_r.picked_realtime;
  assign out_rsp.go_idle         = out_r.go_idle;
  assign out_rsp.preempt         = out_r.preempt;
  assign out_rsp.bad_prio        = out_r.bad_prio;

endmodule

@@ rtl/core/prqd_checker.sv @@
// port-level checks for the run queue dispatcher, bound to the top level
// depends on prqd_pkg and priority_run_queue_dispatcher_assert.svh
`include "priority_run_queue_dispatcher_assert.svh"

module prqd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [prqd_pkg::ID_W-1:0]   out_picked_id,
  input logic [prqd_pkg::PRIO_W-1:0] out_picked_prio,
  input logic                        out_picked_realtime,
  input logic                        out_go_idle,
  input logic                        out_preempt,
  input logic                        out_bad_prio
);

  // one request at a time: busy right after taking one
  `PRQD_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  // idle response carries no thread and no enqueue flags
  `PRQD_IMPLY(a_idle_clean, out_valid && out_go_idle, (out_picked_id == '0) && (out_picked_prio == '0) && !out_picked_realtime && !out_preempt && !out_bad_prio)

  // enqueue flags never mix with pick fields, and a drop never preempts
  `PRQD_IMPLY(a_enq_clean, out_valid && (out_preempt || out_bad_prio), (out_picked_id == '0) && !out_picked_realtime && !out_go_idle && !(out_preempt && out_bad_prio))

  // rt picks always come from the rt priority band
  `PRQD_IMPLY(a_rt_band, out_valid && out_picked_realtime, out_picked_prio >= prqd_pkg::PRIO_W'(prqd_pkg::RT_FIRST_LEVEL))

  // stalled response holds
  `PRQD_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(out_picked_id) && $stable(out_picked_prio) && $stable(out_preempt))

endmodule

bind priority_run_queue_dispatcher prqd_checker u_prqd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_req.valid),
  .in_ready            (in_req.ready),
  .out_valid           (out_rsp.valid),
  .out_ready           (out_rsp.ready),
  .out_picked_id       (out_rsp.picked_id),
  .out_picked_prio     (out_rsp.picked_prio),
  .out_picked_realtime (out_rsp.picked_realtime),
  .out_go_idle         (out_rsp.go_idle),
  .out_preempt         (out_rsp.preempt),
  .out_bad_prio        (out_rsp.bad_prio)
);

@@ tb/sv/tb.sv @@
// self-checking testbench for priority_run_queue_dispatcher: directed, pressure and random requests
// predicts every response from its own model of the run queues and checks it on out_rsp
// depends on prqd_pkg, prqd_chan_if and the dispatcher rtl
module tb;
  import prqd_pkg::*;

  localparam int     CLK_HALF        = 6;
  localparam int     RESET_CYCLES    = 7;
  localparam int     DRAIN_CYCLES    = 20;
  localparam int     RANDOM_REQUESTS = 1700;
  localparam int     MAX_REPORTS     = 10;
  localparam int     LONG_HOLD       = 300;
  localparam longint TIMEOUT_CYCLES  = 600000;

  // receiver pacing styles
  localparam int PACE_OPEN     = 0;
  localparam int PACE_RANDOM   = 1;
  localparam int PACE_PERIODIC = 2;

  // priority spreads for random enqueues
  localparam int SPREAD_FULL     = 0;
  localparam int SPREAD_TOP      = 1;
  localparam int SPREAD_BOUNDARY = 2;

  logic clk;
  logic rst_n;

  prqd_in_if  in_req ();
  prqd_out_if out_rsp ();

  priority_run_queue_dispatcher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  // shadow run queues
  logic [ID_W-1:0]       nxt_link [NUM_THREADS];
  logic [ID_W-1:0]       lvl_head [NUM_LEVELS];
  logic [ID_W-1:0]       lvl_tail [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] lvl_map = '0;
  logic [ID_W-1:0]       rtq_head [RT_LEVELS];
  logic [ID_W-1:0]       rtq_tail [RT_LEVELS];
  logic [RT_LEVELS-1:0]  rtq_map = '0;
  bit                    thread_queued [NUM_THREADS];

  // shadow record of the running thread
  bit                    run_idle = 1'b1;
  logic [PRIO_W-1:0]     run_prio = '0;
  bit                    run_rt   = 1'b0;

  result_t pending_results [$];

  int mismatch_count = 0;
  int n_enqueues     = 0;
  int n_dropped      = 0;
  int n_picks        = 0;
  int n_idle_picks   = 0;
  int n_preempts     = 0;
  int n_queued       = 0;
  int peak_queued    = 0;
  int hold_rsp_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("timeout with %0d responses outstanding", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int highest_set(input logic [NUM_LEVELS-1:0] v);
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (v[i]) return i;
    end
    return -1;
  endfunction

  // expected response of one accepted request, updating the shadow queues
  function automatic result_t predict_dispatch(input logic act, input logic [ID_W-1:0] id,
                                               input logic [PRIO_W-1:0] prio, input logic rt);
    result_t              r;
    int                   ts_top;
    int                   rt_top;
    logic [RT_IDX_W-1:0]  k;
    logic [ID_W-1:0]      h;
    r = '0;
    if (act == ACT_ENQUEUE) begin
      n_enqueues++;
      if (rt && prio < RT_FIRST_LEVEL) begin
        // real-time priority below the real-time band: dropped
        r.bad_prio = 1'b1;
        n_dropped++;
      end else if (rt) begin
        k = RT_IDX_W'(prio - RT_FIRST_LEVEL);
        if (rtq_map[k]) nxt_link[rtq_tail[k]] = id;
        else rtq_head[k] = id;
        rtq_tail[k] = id;
        rtq_map[k]  = 1'b1;
        r.preempt = run_idle || !run_rt || (prio > run_prio);
      end else begin
        if (lvl_map[prio]) nxt_link[lvl_tail[prio]] = id;
        else lvl_head[prio] = id;
        lvl_tail[prio] = id;
        lvl_map[prio]  = 1'b1;
        r.preempt = run_idle || (prio >= run_prio);
      end
      if (!r.bad_prio) begin
        thread_queued[id] = 1'b1;
        n_queued++;
        if (n_queued > peak_queued) peak_queued = n_queued;
      end
    end else begin
      n_picks++;
      ts_top = highest_set(lvl_map);
      rt_top = highest_set(NUM_LEVELS'(rtq_map));
      // real-time level wins a tie with a local level
      if (rt_top >= 0 && rt_top + RT_FIRST_LEVEL >= ts_top) begin
        k = RT_IDX_W'(rt_top);
        h = rtq_head[k];
        if (h == rtq_tail[k]) rtq_map[k] = 1'b0;
        else rtq_head[k] = nxt_link[h];
        r.picked_id       = h;
        r.picked_prio     = PRIO_W'(rt_top + RT_FIRST_LEVEL);
        r.picked_realtime = 1'b1;
      end else if (ts_top >= 0) begin
        h = lvl_head[ts_top];
        if (h == lvl_tail[ts_top]) lvl_map[ts_top] = 1'b0;
        else lvl_head[ts_top] = nxt_link[h];
        r.picked_id   = h;
        r.picked_prio = PRIO_W'(ts_top);
      end else begin
        r.go_idle = 1'b1;
        n_idle_picks++;
      end
      if (!r.go_idle) begin
        thread_queued[r.picked_id] = 1'b0;
        n_queued--;
      end
      run_idle = r.go_idle;
      run_prio = r.picked_prio;
      run_rt   = r.picked_realtime;
    end
    if (r.preempt) n_preempts++;
    return r;
  endfunction

  // offer one request and wait for its acceptance
  task automatic send_request(input logic act, input logic [ID_W-1:0] id,
                              input logic [PRIO_W-1:0] prio, input logic rt);
    in_req.valid        <= 1'b1;
    in_req.action       <= act;
    in_req.thread_id    <= id;
    in_req.prio         <= prio;
    in_req.realtime_req <= rt;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    pending_results.push_back(predict_dispatch(act, id, prio, rt));
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_req.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold off until every predicted response has been checked
  task automatic wait_for_results();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // random request; enqueues use only threads that are not queued yet
  task automatic send_random_request(input int enq_pct, input int spread);
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              rt;
    bit                enq;
    int                start;
    int                free_id;
    id    = ID_W'($urandom);
    prio  = PRIO_W'($urandom);
    rt    = 1'($urandom);
    enq   = $urandom_range(0, 99) < enq_pct;
    if (enq) begin
      case (spread)
        SPREAD_TOP: begin
          prio = PRIO_W'($urandom_range(60, 63));
          if (rt && $urandom_range(0, 19) == 0) prio = PRIO_W'($urandom_range(0, 31));
        end
        SPREAD_BOUNDARY: prio = PRIO_W'($urandom_range(28, 35));
        default: if (rt && $urandom_range(0, 9) != 0) prio[PRIO_W-1] = 1'b1;
      endcase
      if (!(rt && prio < RT_FIRST_LEVEL)) begin
        start   = $urandom_range(0, NUM_THREADS - 1);
        free_id = -1;
        for (int i = 0; i < NUM_THREADS; i++) begin
          if (free_id < 0 && !thread_queued[(start + i) % NUM_THREADS])
            free_id = (start + i) % NUM_THREADS;
        end
        // every thread already queued: pick instead
        if (free_id < 0) enq = 1'b0;
        else id = ID_W'(free_id);
      end
    end
    send_request(enq ? ACT_ENQUEUE : ACT_PICK, id, prio, rt);
  endtask

  // empty queue, field extremes, bad priorities, ties and preempt rules
  task automatic test_directed_cases();
    send_request(ACT_PICK,    6'd0,  6'd0,  1'b0);  // nothing ready
    send_request(ACT_ENQUEUE, 6'd0,  6'd0,  1'b0);  // idle current thread
    send_request(ACT_ENQUEUE, 6'd63, 6'd63, 1'b0);
    send_request(ACT_ENQUEUE, 6'd5,  6'd63, 1'b0);  // second thread on one level
    send_request(ACT_ENQUEUE, 6'd7,  6'd63, 1'b1);  // top real-time level
    send_request(ACT_ENQUEUE, 6'd9,  6'd32, 1'b1);  // lowest real-time level
    send_request(ACT_ENQUEUE, 6'd11, 6'd31, 1'b1);  // just below the real-time band
    send_request(ACT_ENQUEUE, 6'd12, 6'd0,  1'b1);
    send_request(ACT_PICK,    6'd0,  6'd0,  1'b0);  // real-time wins the tie at 63
    send_request(ACT_ENQUEUE, 6'd13, 6'd63, 1'b1);  // equal real-time priority
    send_request(ACT_ENQUEUE, 6'd14, 6'd62, 1'b0);  // lower local under real-time
    send_request(ACT_PICK,    6'd0,  6'd0,  1'b0);
    send_request(ACT_PICK,    6'd0,  6'd0,  1'b0);  // local 63 beats real-time 32
    send_request(ACT_ENQUEUE, 6'd20, 6'd33, 1'b1);  // real-time over local current
    send_request(ACT_ENQUEUE, 6'd21, 6'd63, 1'b0);  // equal local priority
    send_request(ACT_ENQUEUE, 6'd22, 6'd1,  1'b0);  // lower local priority
    repeat (9) send_request(ACT_PICK, 6'd63, 6'd63, 1'b1);  // drain down to idle
    wait_for_results();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure_fill();
    hold_rsp_cycles = LONG_HOLD;
    repeat (20) send_random_request(80, SPREAD_FULL);
    wait_for_results();
  endtask

  // phases of random traffic with varying mix, spread and sender gaps
  task automatic test_random_traffic(input int n_requests);
    int sent;
    int in_phase;
    int phase_len;
    int enq_pct;
    int spread;
    int burst;
    bit no_gaps;
    sent = 0;
    while (sent < n_requests) begin
      phase_len = $urandom_range(40, 160);
      spread    = $urandom_range(SPREAD_FULL, SPREAD_BOUNDARY);
      no_gaps   = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       enq_pct = 30;
        1:       enq_pct = 50;
        2:       enq_pct = 70;
        default: enq_pct = 88;
      endcase
      in_phase = 0;
      while (in_phase < phase_len && sent < n_requests) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          send_random_request(enq_pct, spread);
          sent++;
          in_phase++;
        end
        if (!no_gaps) idle_sender($urandom_range(0, 6));
      end
      if ($urandom_range(0, 4) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // receiver pacing, with a long hold-off on request
  initial begin : rsp_pacer
    int seg_len;
    int seg_mode;
    int c;
    out_rsp.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      seg_len  = $urandom_range(10, 80);
      seg_mode = $urandom_range(PACE_OPEN, PACE_PERIODIC);
      for (c = 0; c < seg_len; c++) begin
        if (hold_rsp_cycles > 0) begin
          out_rsp.ready <= 1'b0;
          repeat (hold_rsp_cycles) @(posedge clk);
          hold_rsp_cycles = 0;
        end else begin
          case (seg_mode)
            PACE_OPEN:   out_rsp.ready <= 1'b1;
            PACE_RANDOM: out_rsp.ready <= ($urandom_range(0, 3) != 0);
            default:     out_rsp.ready <= (c % 3 != 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // response check against the oldest prediction
  always @(posedge clk) begin : rsp_check
    result_t got;
    result_t want;
    bit      wrong;
    if (rst_n === 1'b1 && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      got.picked_id       = out_rsp.picked_id;
      got.picked_prio     = out_rsp.picked_prio;
      got.picked_realtime = out_rsp.picked_realtime;
      got.go_idle         = out_rsp.go_idle;
      got.preempt         = out_rsp.preempt;
      got.bad_prio        = out_rsp.bad_prio;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected response: id=%0d prio=%0d rt=%0b idle=%0b pre=%0b bad=%0b",
                   got.picked_id, got.picked_prio, got.picked_realtime, got.go_idle,
                   got.preempt, got.bad_prio);
      end else begin
        want  = pending_results.pop_front();
        wrong = (got.picked_id !== want.picked_id) || (got.picked_prio !== want.picked_prio) ||
                (got.picked_realtime !== want.picked_realtime) ||
                (got.go_idle !== want.go_idle) || (got.preempt !== want.preempt) ||
                (got.bad_prio !== want.bad_prio);
        if (wrong) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: want id=%0d prio=%0d rt=%0b idle=%0b pre=%0b bad=%0b",
                     $realtime, want.picked_id, want.picked_prio, want.picked_realtime,
                     want.go_idle, want.preempt, want.bad_prio);
            $display("                 got  id=%0d prio=%0d rt=%0b idle=%0b pre=%0b bad=%0b",
                     got.picked_id, got.picked_prio, got.picked_realtime, got.go_idle,
                     got.preempt, got.bad_prio);
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    rst_n               <= 1'b0;
    in_req.valid        <= 1'b0;
    in_req.action       <= ACT_ENQUEUE;
    in_req.thread_id    <= '0;
    in_req.prio         <= '0;
    in_req.realtime_req <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_backpressure_fill();
    test_random_traffic(RANDOM_REQUESTS);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d enqueues (%0d dropped for bad priority) and %0d picks (%0d idle)",
             n_enqueues, n_dropped, n_picks, n_idle_picks);
    $display("%0d preemptions flagged, up to %0d threads queued, %0d mismatches",
             n_preempts, peak_queued, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ priority_run_queue_dispatcher.f @@
+incdir+rtl/core
rtl/core/prqd_pkg.sv
rtl/core/prqd_chan_if.sv
rtl/core/prqd_ram.sv
rtl/core/priority_run_queue_dispatcher.sv
rtl/core/prqd_checker.sv
tb/sv/tb.sv
